/* rtl/salru_pkg.sv */
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types, constants and helpers for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salru_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;

  localparam int TAG_W   = 32;
  localparam int TOTAL_W = 32;
  localparam int ADDR_W  = 32;
  localparam int RANK_W  = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // Trace operations
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_OTHER  = 2'd3;

  // First-access outcome codes
  localparam logic [1:0] OUT_NONE  = 2'd0;
  localparam logic [1:0] OUT_HIT   = 2'd1;
  localparam logic [1:0] OUT_MISS  = 2'd2;
  localparam logic [1:0] OUT_EVICT = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef struct packed {
    logic clear;    // zero one metadata row of the reset sweep
    logic capture;  // take an item, start the set read
    logic finish;   // write the set back, update totals, load the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_sts_t;

  // Saturating add of a small increment to a running total
  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
                                                 input logic [1:0] inc);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, total} + (TOTAL_W+1)'(inc);
    return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  endfunction

endpackage

/* rtl/salru_ram.sv */
// ----------------------------------------------------------------------------
// salru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/salru_ctrl.sv */
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer: reset sweep, item capture, lookup/write-back, result handshake.
// ----------------------------------------------------------------------------
module salru_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  salru_pkg::dp_sts_t   sts,
  output salru_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == ST_CLEAR);
    cmd.capture = (state == ST_IDLE) && in_valid;
    cmd.finish  = (state == ST_LOOKUP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.sweep_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/salru_dp.sv */
// ----------------------------------------------------------------------------
// salru_dp
// Datapath: config registers, address split, set RAMs, way compare, LRU
// update and saturating totals.
// ----------------------------------------------------------------------------
module salru_dp #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS     = salru_pkg::MAX_WAYS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  salru_pkg::ctrl_cmd_t                cmd,
  output salru_pkg::dp_sts_t                  sts,
  input  logic                                cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [1:0]                          opcode,
  input  logic [salru_pkg::ADDR_W-1:0]        address,
  output logic [1:0]                          outcome,
  output logic                                second_hit,
  output logic [salru_pkg::TOTAL_W-1:0]       hit_total,
  output logic [salru_pkg::TOTAL_W-1:0]       miss_total,
  output logic [salru_pkg::TOTAL_W-1:0]       eviction_total
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = salru_pkg::RANK_W;
  localparam int TAG_W  = salru_pkg::TAG_W;
  localparam int META_W = MAX_WAYS * (1 + RANK_W);
  localparam int TROW_W = MAX_WAYS * TAG_W;

  // Configuration
  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd0;
      block_bits  <= 5'd0;
      ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salru_pkg::CFG_SET_BITS:   set_bits    <= cfg_data[2:0];
        salru_pkg::CFG_BLOCK_BITS: block_bits  <= cfg_data[4:0];
        salru_pkg::CFG_WAYS:       ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Address split at capture
  logic [3:0]       sb;
  logic [5:0]       tag_shift;
  logic [31:0]      set_mask;
  logic [31:0]      set_full;
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  assign sb        = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                             : {1'b0, set_bits};
  assign tag_shift = 6'(sb) + 6'(block_bits);
  assign set_mask  = 32'((33'd1 << sb) - 33'd1);
  assign set_full  = (address >> block_bits) & set_mask;
  assign set_in    = set_full[SET_W-1:0];
  assign tag_in    = address >> tag_shift;

  logic [1:0]       op_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= opcode;
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Reset sweep over metadata rows
  logic [SET_W-1:0] sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.clear) begin
      sweep <= sweep + SET_W'(1);
    end
  end

  always_comb begin
    sts            = '0;
    sts.sweep_last = (sweep == SET_W'(SETS - 1));
  end

  // Set storage: metadata row (valid bits, ranks) and tag row
  logic [META_W-1:0] meta_rd, meta_wd;
  logic [TROW_W-1:0] tag_rd, tag_wd;
  logic              access_we;
  logic              meta_we;
  logic [SET_W-1:0]  meta_waddr;

  assign access_we  = cmd.finish && (op_q != salru_pkg::OP_OTHER);
  assign meta_we    = cmd.clear || access_we;
  assign meta_waddr = cmd.clear ? sweep : set_q;

  salru_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (cmd.clear ? META_W'(0) : meta_wd),
    .re    (cmd.capture),
    .raddr (set_in),
    .rdata (meta_rd)
  );

  salru_ram #(.WIDTH(TROW_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (access_we),
    .waddr (set_q),
    .wdata (tag_wd),
    .re    (cmd.capture),
    .raddr (set_in),
    .rdata (tag_rd)
  );

  // Way compare and LRU update
  logic [4:0]          ways_eff;
  logic [MAX_WAYS-1:0] en, vld, vld_n;
  logic [RANK_W-1:0]   rec   [MAX_WAYS];
  logic [RANK_W-1:0]   rec_n [MAX_WAYS];
  logic [TAG_W-1:0]    tg    [MAX_WAYS];
  logic                hit_found, inv_found;
  logic [WAY_W-1:0]    hit_way, inv_way, vic_way, sel_way;
  logic [RANK_W-1:0]   hit_rec, vic_rec;
  logic [RANK_W:0]     limit;
  logic [1:0]          outcome_c;

  assign ways_eff = (ways_in_use == 4'd0) ? 5'd1 :
                    ({1'b0, ways_in_use} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS)
                                                         : {1'b0, ways_in_use};

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      en[i]  = (5'(i) < ways_eff);
      vld[i] = meta_rd[i];
      rec[i] = meta_rd[MAX_WAYS + i*RANK_W +: RANK_W];
      tg[i]  = tag_rd[i*TAG_W +: TAG_W];
    end
  end

  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    hit_rec   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    vic_way   = '0;
    vic_rec   = rec[0];
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!hit_found && en[i] && vld[i] && (tg[i] == tag_q)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
        hit_rec   = rec[i];
      end
      if (!inv_found && en[i] && !vld[i]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
      // strict compare keeps the lowest way on equal ranks
      if (en[i] && (rec[i] > vic_rec)) begin
        vic_way = WAY_W'(i);
        vic_rec = rec[i];
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      sel_way   = hit_way;
      limit     = {1'b0, hit_rec};
      outcome_c = salru_pkg::OUT_HIT;
    end else if (inv_found) begin
      sel_way   = inv_way;
      limit     = {1'b0, salru_pkg::RANK_MAX} + (RANK_W+1)'(1);
      outcome_c = salru_pkg::OUT_MISS;
    end else begin
      sel_way   = vic_way;
      limit     = {1'b0, vic_rec};
      outcome_c = salru_pkg::OUT_EVICT;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      rec_n[i] = rec[i];
      vld_n[i] = vld[i];
      if (WAY_W'(i) == sel_way) begin
        rec_n[i] = '0;
        vld_n[i] = 1'b1;
      end else if (en[i] && vld[i] && ({1'b0, rec[i]} < limit)
                   && (rec[i] != salru_pkg::RANK_MAX)) begin
        rec_n[i] = rec[i] + RANK_W'(1);
      end
      meta_wd[MAX_WAYS + i*RANK_W +: RANK_W] = rec_n[i];
      tag_wd[i*TAG_W +: TAG_W] = (WAY_W'(i) == sel_way) ? tag_q : tg[i];
    end
    meta_wd[MAX_WAYS-1:0] = vld_n;
  end

  // Totals and result payload
  logic [1:0] inc_hit;
  logic [1:0] inc_miss;
  logic [1:0] inc_evict;
  logic       is_modify;

  assign is_modify = (op_q == salru_pkg::OP_MODIFY);
  // modify's second access always hits the line just touched
  assign inc_hit   = {1'b0, (outcome_c == salru_pkg::OUT_HIT)} + {1'b0, is_modify};
  assign inc_miss  = {1'b0, (outcome_c != salru_pkg::OUT_HIT)};
  assign inc_evict = {1'b0, (outcome_c == salru_pkg::OUT_EVICT)};

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else if (access_we) begin
      hit_total      <= salru_pkg::sat_add(hit_total, inc_hit);
      miss_total     <= salru_pkg::sat_add(miss_total, inc_miss);
      eviction_total <= salru_pkg::sat_add(eviction_total, inc_evict);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      outcome    <= access_we ? outcome_c : salru_pkg::OUT_NONE;
      second_hit <= access_we && is_modify;
    end
  end

endmodule

/* rtl/set_assoc_cache_lru_sim.sv */
// Result: the set row is read at the accepting edge, then compared and written
// back once the result register is free. A new item is taken only after the last
// one's set row has been read and written back in the tag and metadata RAMs.
// Reset: synchronous; totals and config return to defaults, then a sweep over
// every row of the metadata RAM clears it before in_ready rises.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag-only set-associative cache model with LRU replacement and hit, miss
// and eviction totals.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = salru_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS     = salru_pkg::MAX_WAYS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic [salru_pkg::ADDR_W-1:0]     address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       outcome,
  output logic                             second_hit,
  output logic [salru_pkg::TOTAL_W-1:0]    hit_total,
  output logic [salru_pkg::TOTAL_W-1:0]    miss_total,
  output logic [salru_pkg::TOTAL_W-1:0]    eviction_total
);

  salru_pkg::ctrl_cmd_t cmd;
  salru_pkg::dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  salru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  salru_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .address        (address),
    .outcome        (outcome),
    .second_hit     (second_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache testbench
// Feeds load, store, modify and other trace items to the cache model over
// several geometries and checks every result item against a local predictor
// of the tag store, LRU ranks and saturating hit/miss/eviction totals.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [salru_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LINES = (1 << salru_pkg::MAX_SET_BITS) * salru_pkg::MAX_WAYS;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
  } trace_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        second_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } cache_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [salru_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = OP_LOAD;
  logic [salru_pkg::ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic second_hit;
  logic [salru_pkg::TOTAL_W-1:0] hit_total;
  logic [salru_pkg::TOTAL_W-1:0] miss_total;
  logic [salru_pkg::TOTAL_W-1:0] eviction_total;

  set_assoc_cache_lru_sim i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .outcome        (outcome),
    .second_hit     (second_hit),
    .hit_total      (hit_total),
    .miss_total     (miss_total),
    .eviction_total (eviction_total)
  );

  // Predictor state: tag store, LRU ranks, totals and geometry
  logic        way_vld [LINES] = '{default: 1'b0};
  logic [31:0] way_tag [LINES] = '{default: 32'd0};
  logic [2:0]  way_age [LINES] = '{default: 3'd0};
  logic [31:0] hit_cnt = '0;
  logic [31:0] miss_cnt = '0;
  logic [31:0] evict_cnt = '0;
  logic [2:0]  geo_sets = 3'd0;
  logic [4:0]  geo_block = 5'd0;
  logic [3:0]  geo_ways = 4'd1;

  trace_item_t   trace_q[$];
  trace_item_t   next_item;
  cache_result_t results_due[$];
  cache_result_t want;
  cache_result_t seen;

  int  send_idle = 34;
  int  recv_idle = 58;
  int  errors = 0;
  int  cycle_count = 0;
  int  hold_left = 0;
  logic hold_kick = 1'b0;
  logic hold_seen = 1'b0;

  function automatic logic [31:0] bump_total(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  // Make way w most recent; valid ways in use ranked below limit age by one
  function automatic void age_lines(input int base, input int ways, input int w,
                                    input int limit);
    int i;
    for (i = 0; i < ways; i++) begin
      if (i != w && way_vld[base+i] && int'(way_age[base+i]) < limit &&
          way_age[base+i] < salru_pkg::RANK_MAX)
        way_age[base+i] = way_age[base+i] + 3'd1;
    end
    way_age[base+w] = 3'd0;
  endfunction

  function automatic logic [1:0] cache_access(input logic [31:0] addr);
    int sb, ways, base, victim, i;
    logic [63:0] wide;
    logic [31:0] set_idx, tag_val;
    sb = (geo_sets > salru_pkg::MAX_SET_BITS) ? salru_pkg::MAX_SET_BITS : int'(geo_sets);
    ways = (geo_ways == 0) ? 1 :
           (geo_ways > salru_pkg::MAX_WAYS ? salru_pkg::MAX_WAYS : int'(geo_ways));
    wide = {32'd0, addr};
    set_idx = 32'((wide >> geo_block) & ((64'd1 << sb) - 64'd1));
    tag_val = 32'(wide >> (sb + int'(geo_block)));
    base = int'(set_idx) * salru_pkg::MAX_WAYS;
    for (i = 0; i < ways; i++) begin
      if (way_vld[base+i] && way_tag[base+i] == tag_val) begin
        age_lines(base, ways, i, int'(way_age[base+i]));
        hit_cnt = bump_total(hit_cnt);
        return salru_pkg::OUT_HIT;
      end
    end
    for (i = 0; i < ways; i++) begin
      if (!way_vld[base+i]) begin
        age_lines(base, ways, i, int'(salru_pkg::RANK_MAX) + 1);
        way_vld[base+i] = 1'b1;
        way_tag[base+i] = tag_val;
        miss_cnt = bump_total(miss_cnt);
        return salru_pkg::OUT_MISS;
      end
    end
    victim = 0;
    for (i = 1; i < ways; i++)
      if (way_age[base+i] > way_age[base+victim]) victim = i;
    age_lines(base, ways, victim, int'(way_age[base+victim]));
    way_tag[base+victim] = tag_val;
    miss_cnt = bump_total(miss_cnt);
    evict_cnt = bump_total(evict_cnt);
    return salru_pkg::OUT_EVICT;
  endfunction

  function automatic cache_result_t cache_predict(input logic [1:0] op,
                                                  input logic [31:0] addr);
    cache_result_t r;
    r.outcome = salru_pkg::OUT_NONE;
    r.second_hit = 1'b0;
    if (op != salru_pkg::OP_OTHER) r.outcome = cache_access(addr);
    if (op == salru_pkg::OP_MODIFY)
      r.second_hit = (cache_access(addr) == salru_pkg::OUT_HIT);
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evictions = evict_cnt;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: one trace item at a time, predicted when accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) results_due.push_back(cache_predict(opcode, address));
      if (trace_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        next_item = trace_q.pop_front();
        in_valid <= 1'b1;
        opcode <= next_item.op;
        address <= next_item.addr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here once kicked
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {outcome, second_hit, hit_total, miss_total, eviction_total};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result outcome=%0d hits=%0d misses=%0d evictions=%0d",
                   $time, seen.outcome, seen.hits, seen.misses, seen.evictions);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (seen !== want) begin
            $display("%0t: expected outcome=%0d second_hit=%0d hits=%0d misses=%0d evictions=%0d",
                     $time, want.outcome, want.second_hit, want.hits, want.misses,
                     want.evictions);
            $display("%0t: actual   outcome=%0d second_hit=%0d hits=%0d misses=%0d evictions=%0d",
                     $time, seen.outcome, seen.second_hit, seen.hits, seen.misses,
                     seen.evictions);
            errors++;
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] addr);
    trace_item_t it;
    it.op = op;
    it.addr = addr;
    trace_q.push_back(it);
  endtask

  // Returns once no item is queued, in flight or awaiting its result
  task automatic drain();
    do @(posedge clk);
    while (trace_q.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  // Call just after the clock rises; leaves cfg_valid high for the caller
  task automatic write_reg(input logic [salru_pkg::CFG_IDX_W-1:0] idx,
                           input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      salru_pkg::CFG_SET_BITS:   geo_sets = val[2:0];
      salru_pkg::CFG_BLOCK_BITS: geo_block = val;
      salru_pkg::CFG_WAYS:       geo_ways = val[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [4:0] sets_val, input logic [4:0] block_val,
                           input logic [4:0] ways_val);
    write_reg(salru_pkg::CFG_SET_BITS, sets_val);
    write_reg(salru_pkg::CFG_BLOCK_BITS, block_val);
    write_reg(salru_pkg::CFG_WAYS, ways_val);
    cfg_valid <= 1'b0;
  endtask

  // Random items clustered on a few tags and sets of the current geometry
  task automatic random_phase(input logic [4:0] sets_val, input logic [4:0] block_val,
                              input logic [4:0] ways_val, input int s_idle,
                              input int r_idle, input bit long_hold);
    int sb, ways, n;
    logic [63:0] wide;
    drain();
    configure(sets_val, block_val, ways_val);
    sb = (sets_val[2:0] > salru_pkg::MAX_SET_BITS) ? salru_pkg::MAX_SET_BITS
                                                   : int'(sets_val[2:0]);
    ways = (ways_val[3:0] == 0) ? 1 :
           (ways_val[3:0] > salru_pkg::MAX_WAYS ? salru_pkg::MAX_WAYS
                                                : int'(ways_val[3:0]));
    send_idle <= s_idle;
    recv_idle <= r_idle;
    if (long_hold) hold_kick <= ~hold_kick;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(99) < 15) begin
        wide = {32'd0, $urandom};
      end else begin
        wide = (64'($urandom_range(ways + 2)) << (sb + int'(block_val))) |
               ((64'($urandom_range(3)) & ((64'd1 << sb) - 64'd1)) << block_val) |
               (64'($urandom) & ((64'd1 << block_val) - 64'd1));
      end
      push_item(2'($urandom_range(3)), wide[31:0]);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: one set, one way, tag is the whole address
    push_item(OP_LOAD, 32'h0000_0000);
    push_item(OP_LOAD, 32'h0000_0000);
    push_item(OP_STORE, 32'h0000_0001);
    push_item(salru_pkg::OP_MODIFY, 32'h0000_0001);
    push_item(salru_pkg::OP_MODIFY, 32'h0000_0002);
    push_item(salru_pkg::OP_OTHER, 32'hffff_ffff);
    push_item(OP_LOAD, 32'hffff_ffff);
    push_item(OP_STORE, 32'hffff_ffff);

    // Four sets of two ways: conflicts in set 0, LRU victim choice
    drain();
    configure(5'd2, 5'd4, 5'd2);
    push_item(OP_LOAD, 32'h0000_0000);
    push_item(OP_LOAD, 32'h0000_0040);
    push_item(OP_LOAD, 32'h0000_0080);
    push_item(OP_LOAD, 32'h0000_0040);
    push_item(OP_STORE, 32'h0000_0000);
    push_item(salru_pkg::OP_MODIFY, 32'h0000_00c0);
    push_item(salru_pkg::OP_OTHER, 32'h1234_5678);

    // Set bits saturate, offset wide enough that the tag is always zero, ways 0
    drain();
    configure(5'd31, 5'd26, 5'd0);
    push_item(OP_LOAD, 32'hffff_ffff);
    push_item(OP_STORE, 32'h0000_0000);
    push_item(salru_pkg::OP_MODIFY, 32'h8000_0000);

    // Widest offset, ways above the maximum, write to the unused index
    drain();
    write_reg(CFG_UNUSED, 5'($urandom));
    configure(5'd6, 5'd31, 5'd15);
    push_item(OP_LOAD, 32'hffff_ffff);
    push_item(OP_LOAD, 32'h7fff_ffff);
    push_item(salru_pkg::OP_MODIFY, 32'h0000_0000);

    random_phase(5'd0, 5'd0, 5'd1, 34, 58, 1'b0);
    random_phase(5'($urandom_range(6)), 5'($urandom_range(10)), 5'($urandom_range(1, 8)),
                 34, 58, 1'b1);
    random_phase(5'd6, 5'd26, 5'd8, 34, 58, 1'b0);
    random_phase(5'($urandom), 5'($urandom), 5'($urandom), 58, 34, 1'b0);
    random_phase(5'($urandom_range(6)), 5'($urandom_range(8)), 5'($urandom_range(1, 8)),
                 58, 34, 1'b1);
    random_phase(5'($urandom_range(6)), 5'($urandom_range(12)), 5'($urandom), 58, 34, 1'b0);
    random_phase(5'($urandom), 5'($urandom_range(16, 31)), 5'($urandom), 0, 0, 1'b0);
    random_phase(5'd2, 5'd4, 5'd8, 0, 0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/salru_pkg.sv
rtl/salru_ram.sv
rtl/salru_ctrl.sv
rtl/salru_dp.sv
rtl/set_assoc_cache_lru_sim.sv
dv/testbench.sv
